@@ design/lbvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types and constants for the label box and volume statistics block.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int LABEL_COUNT = 256;
  localparam int LABEL_BITS  = $clog2(LABEL_COUNT);
  localparam int COORD_BITS  = 10;
  localparam int DIM_BITS    = COORD_BITS + 1;
  localparam int CNT_BITS    = 30;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CNT_BITS-1:0]   CNT_MAX   = {CNT_BITS{1'b1}};
  localparam logic [DIM_BITS-1:0]   DIM_RESET = DIM_BITS'(1 << COORD_BITS);
  localparam logic [LABEL_BITS-1:0] TOP_LABEL_RESET = LABEL_BITS'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Z = 2'd2;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  // what the back end does with a queued item
  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] z;
  } dims_t;

  typedef struct packed {
    op_t                   op;
    logic [LABEL_BITS-1:0] label;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] lo_x;
    logic [COORD_BITS-1:0] lo_y;
    logic [COORD_BITS-1:0] lo_z;
    logic [COORD_BITS-1:0] hi_x;
    logic [COORD_BITS-1:0] hi_y;
    logic [COORD_BITS-1:0] hi_z;
    logic [CNT_BITS-1:0]   count;
  } entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/lbvs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbvs_front
// Holds the dimension registers and classifies each incoming request.
// ----------------------------------------------------------------------------
module lbvs_front import lbvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data,
  input  logic [1:0]              req_type,
  input  logic [LABEL_BITS-1:0]   voxel_label,
  input  logic [COORD_BITS-1:0]   pos_x,
  input  logic [COORD_BITS-1:0]   pos_y,
  input  logic [COORD_BITS-1:0]   pos_z,
  output item_t                   item,
  output dims_t                   dims
);

  dims_t dims_reg;
  logic  outside;
  req_t  req;

  assign cfg_ready = 1'b1;
  assign dims      = dims_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_reg <= '{x: DIM_RESET, y: DIM_RESET, z: DIM_RESET};
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DIM_X) dims_reg.x <= cfg_data;
      if (cfg_index == CFG_DIM_Y) dims_reg.y <= cfg_data;
      if (cfg_index == CFG_DIM_Z) dims_reg.z <= cfg_data;
    end
  end

  always_comb begin
    req     = req_t'(req_type);
    outside = ({1'b0, pos_x} >= dims_reg.x) || ({1'b0, pos_y} >= dims_reg.y) ||
              ({1'b0, pos_z} >= dims_reg.z);
    item.label = voxel_label;
    item.x     = pos_x;
    item.y     = pos_y;
    item.z     = pos_z;
    unique case (req)
      REQ_ACC: begin
        // background voxels only read back
        if (voxel_label == '0) item.op = OP_READ;
        else if (outside)      item.op = OP_REJECT;
        else                   item.op = OP_ACC;
      end
      REQ_CLEAR: item.op = OP_CLEAR;
      REQ_READ:  item.op = OP_READ;
      REQ_NOP:   item.op = OP_READ;
      default:   item.op = OP_READ;
    endcase
  end

endmodule

@@ design/lbvs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbvs_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module lbvs_queue import lbvs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctrl,
  output q_stat_t stat,
  input  item_t   din,
  output item_t   dout
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  item_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]    fill;

  assign stat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign dout       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (ctrl.push && !ctrl.pop)      fill <= fill + 1'b1;
      else if (!ctrl.push && ctrl.pop) fill <= fill - 1'b1;
    end
  end

endmodule

@@ design/lbvs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbvs_back
// Per-label statistics table, largest-label tracker and result register.
// ----------------------------------------------------------------------------
module lbvs_back import lbvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dims_t                 dims,
  input  q_stat_t               q_stat,
  output logic                  q_pop,
  input  item_t                 q_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LABEL_BITS-1:0] largest_label,
  output logic [CNT_BITS-1:0]   largest_count,
  output logic [DIM_BITS-1:0]   box_low_x,
  output logic [DIM_BITS-1:0]   box_low_y,
  output logic [DIM_BITS-1:0]   box_low_z,
  output logic [COORD_BITS-1:0] box_high_x,
  output logic [COORD_BITS-1:0] box_high_y,
  output logic [COORD_BITS-1:0] box_high_z,
  output logic [CNT_BITS-1:0]   label_count,
  output logic                  status
);

  entry_t mem [LABEL_COUNT];
  entry_t rd_data;
  logic   rd_en;
  logic   wr_en;

  state_t state, state_next;
  item_t  cur;
  logic [LABEL_COUNT-1:0] entry_valid;
  logic [LABEL_BITS-1:0]  top_label, top_label_next;
  logic [CNT_BITS-1:0]    top_count, top_count_next;

  logic   hit;
  logic   show_valid;
  logic   load_out;
  entry_t acc_entry;
  entry_t show_entry;
  logic [CNT_BITS-1:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[q_item.label];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cur.label] <= acc_entry;
  end

  always_comb begin
    hit     = entry_valid[cur.label];
    cnt_inc = (rd_data.count == CNT_MAX) ? rd_data.count : rd_data.count + 1'b1;
    if (hit) begin
      acc_entry.lo_x  = (cur.x < rd_data.lo_x) ? cur.x : rd_data.lo_x;
      acc_entry.lo_y  = (cur.y < rd_data.lo_y) ? cur.y : rd_data.lo_y;
      acc_entry.lo_z  = (cur.z < rd_data.lo_z) ? cur.z : rd_data.lo_z;
      acc_entry.hi_x  = (cur.x > rd_data.hi_x) ? cur.x : rd_data.hi_x;
      acc_entry.hi_y  = (cur.y > rd_data.hi_y) ? cur.y : rd_data.hi_y;
      acc_entry.hi_z  = (cur.z > rd_data.hi_z) ? cur.z : rd_data.hi_z;
      acc_entry.count = cnt_inc;
    end else begin
      acc_entry.lo_x  = cur.x;
      acc_entry.lo_y  = cur.y;
      acc_entry.lo_z  = cur.z;
      acc_entry.hi_x  = cur.x;
      acc_entry.hi_y  = cur.y;
      acc_entry.hi_z  = cur.z;
      acc_entry.count = CNT_BITS'(1);
    end

    top_label_next = top_label;
    top_count_next = top_count;
    show_entry     = rd_data;
    show_valid     = hit;
    unique case (cur.op)
      OP_ACC: begin
        show_entry = acc_entry;
        show_valid = 1'b1;
        if (cur.label == top_label) begin
          top_count_next = acc_entry.count;
        end else if (acc_entry.count > top_count) begin
          top_label_next = cur.label;
          top_count_next = acc_entry.count;
        end
      end
      OP_CLEAR: begin
        show_valid     = 1'b0;
        top_label_next = TOP_LABEL_RESET;
        top_count_next = '0;
      end
      OP_READ, OP_REJECT: ;
      default: ;
    endcase
  end

  // two-state sequencer: table read, then update and write back
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_stat.empty && (!out_valid || !out_stall)) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wr_en      = (cur.op == OP_ACC);
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
      top_label   <= TOP_LABEL_RESET;
      top_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        top_label <= top_label_next;
        top_count <= top_count_next;
        if (cur.op == OP_CLEAR)    entry_valid <= '0;
        else if (cur.op == OP_ACC) entry_valid[cur.label] <= 1'b1;
      end
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      largest_label <= top_label_next;
      largest_count <= top_count_next;
      status        <= (cur.op == OP_REJECT);
      if (show_valid) begin
        box_low_x   <= {1'b0, show_entry.lo_x};
        box_low_y   <= {1'b0, show_entry.lo_y};
        box_low_z   <= {1'b0, show_entry.lo_z};
        box_high_x  <= show_entry.hi_x;
        box_high_y  <= show_entry.hi_y;
        box_high_z  <= show_entry.hi_z;
        label_count <= show_entry.count;
      end else begin
        box_low_x   <= dims.x;
        box_low_y   <= dims.y;
        box_low_z   <= dims.z;
        box_high_x  <= '0;
        box_high_y  <= '0;
        box_high_z  <= '0;
        label_count <= '0;
      end
    end
  end

endmodule

@@ design/label_box_volume_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_box_volume_stats
// Per-label bounding box and voxel count over a labelled voxel stream.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  in       in_valid / in_stall, request fields  in
//  out      out_valid / out_stall, result fields out
//  cfg      cfg_valid / cfg_ready, index, data   in
//
// The back end handles each item in two steps, the table read and then the
// update and write back over the single-port statistics table, and takes no
// new item until the last is through. An accepted request passes the queue,
// table read and update before its result is valid. Synchronous reset clears
// all labels at once through per-label valid bits; no clearing pass. in_stall
// rises when the two-entry queue is full; a stalled result holds.
module label_box_volume_stats import lbvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [LABEL_BITS-1:0]   voxel_label,
  input  logic [COORD_BITS-1:0]   pos_x,
  input  logic [COORD_BITS-1:0]   pos_y,
  input  logic [COORD_BITS-1:0]   pos_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LABEL_BITS-1:0]   largest_label,
  output logic [CNT_BITS-1:0]     largest_count,
  output logic [DIM_BITS-1:0]     box_low_x,
  output logic [DIM_BITS-1:0]     box_low_y,
  output logic [DIM_BITS-1:0]     box_low_z,
  output logic [COORD_BITS-1:0]   box_high_x,
  output logic [COORD_BITS-1:0]   box_high_y,
  output logic [COORD_BITS-1:0]   box_high_z,
  output logic [CNT_BITS-1:0]     label_count,
  output logic                    status
);

  item_t   front_item;
  item_t   q_item;
  dims_t   dims;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  logic    q_pop;

  assign in_stall    = q_stat.full;
  assign q_ctrl.push = in_valid && !in_stall;
  assign q_ctrl.pop  = q_pop;

  lbvs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .voxel_label (voxel_label),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .item        (front_item),
    .dims        (dims)
  );

  lbvs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (q_ctrl),
    .stat (q_stat),
    .din  (front_item),
    .dout (q_item)
  );

  lbvs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .largest_label (largest_label),
    .largest_count (largest_count),
    .box_low_x     (box_low_x),
    .box_low_y     (box_low_y),
    .box_low_z     (box_low_z),
    .box_high_x    (box_high_x),
    .box_high_y    (box_high_y),
    .box_high_z    (box_high_z),
    .label_count   (label_count),
    .status        (status)
  );

endmodule
